>>> design/masked_byte_pattern_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// masked byte pattern scanner: assertion macros
// shared property wrappers for the scanner's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBPS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// masked byte pattern scanner package
// shared constants, register codes and the per-cell compare settings
// ----------------------------------------------------------------------------
package mbps_pkg;

    // signature bytes held in the pattern registers
    localparam int SIG_BYTES_HELD = 16;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;
    localparam int LEN_W        = 5;
    localparam int OUT_OFFSET_W = 32;

    // register index codes (byte address is 8 * index)
    localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [1:0] REG_CARE_MASK    = 2'd2;
    localparam logic [1:0] REG_PATTERN_LEN  = 2'd3;

    localparam logic [SIG_BYTES_HELD-1:0] CARE_MASK_RST = '1;
    localparam logic [LEN_W-1:0]          PATTERN_LEN_RST = LEN_W'(SIG_BYTES_HELD);

    // compare settings for one window cell, already aligned to its position
    typedef struct packed {
        logic              in_use;
        logic              care;
        logic [BYTE_W-1:0] sig;
    } cell_cfg_t;

endpackage

>>> design/mbps_cell.sv
// ----------------------------------------------------------------------------
// masked byte pattern scanner window cell
// holds one window byte, passes it on, and compares it against its signature byte
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
    input  mbps_pkg::cell_cfg_t         cfg,
    output logic [mbps_pkg::BYTE_W-1:0] byte_q,
    output logic                        hit
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_q = byte_reg;
    // unused positions and wildcards always pass
    assign hit = !cfg.in_use || !cfg.care || (cfg.sig == byte_reg);

endmodule

>>> design/masked_byte_pattern_scanner_unit.sv
// ----------------------------------------------------------------------------
// masked byte pattern scanner unit
// streams a memory image and reports the first offset of a masked byte signature
// ----------------------------------------------------------------------------
// The block takes one image byte per cycle on the s_ side and, at most once per
// image, gives one result transfer on the m_ side: found=1 with the offset of the
// first position where every cared signature byte matches, or found=0 with offset
// 0 on the last byte (s_tlast) if no match was seen. The byte that causes a result
// is first set into the window cells; all cells are then compared in parallel and
// the result is loaded into the output register. The input stalls only while a
// result waits unread in the output register and the byte under test would give
// another one, so the sustained rate is one byte per cycle. Signature, care mask and
// length sit in APB registers at byte addresses 0, 8, 16 and 24; write them
// between images or while nothing is in flight.
`include "masked_byte_pattern_scanner_unit_defines.svh"

module masked_byte_pattern_scanner_unit #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // image byte input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mbps_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] image_byte
    input  logic                            s_tlast,   // end_of_image
    // scan result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mbps_pkg::OUT_OFFSET_W-1:0] m_tdata, // [31:0] match_offset
    output logic                            m_tuser,   // [0] found
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mbps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mbps_pkg::*;

    // longest usable signature: limited by window depth and by bytes held
    localparam int CAP   = (MAX_PATTERN_BYTES < SIG_BYTES_HELD) ? MAX_PATTERN_BYTES
                                                                : SIG_BYTES_HELD;
    localparam int EXT_W = (OFFSET_BITS > OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]     pattern_low_reg;
    logic [CFG_DATA_W-1:0]     pattern_high_reg;
    logic [SIG_BYTES_HELD-1:0] care_mask_reg;
    logic [LEN_W-1:0]          pattern_len_reg;
    logic                      cfg_write;
    logic [1:0]                cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= CARE_MASK_RST;
            pattern_len_reg  <= PATTERN_LEN_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pattern_high_reg <= pwdata;
                REG_CARE_MASK:    care_mask_reg    <= pwdata[SIG_BYTES_HELD-1:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_index)
            REG_PATTERN_LOW:  prdata = pattern_low_reg;
            REG_PATTERN_HIGH: prdata = pattern_high_reg;
            REG_CARE_MASK:    prdata = CFG_DATA_W'(care_mask_reg);
            REG_PATTERN_LEN:  prdata = CFG_DATA_W'(pattern_len_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // per-cell compare settings, aligned to window positions
    // cell p (newest byte at p = 0) checks signature byte len-1-p
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] sig_bytes [SIG_BYTES_HELD];
    logic [LEN_W-1:0]  len_eff;
    cell_cfg_t         cell_cfg_next [MAX_PATTERN_BYTES];
    cell_cfg_t         cell_cfg_reg  [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]  len_eff_reg;

    always_comb begin
        for (int i = 0; i < SIG_BYTES_HELD / 2; i++) begin
            sig_bytes[i]                      = pattern_low_reg[BYTE_W*i +: BYTE_W];
            sig_bytes[i + SIG_BYTES_HELD / 2] = pattern_high_reg[BYTE_W*i +: BYTE_W];
        end
    end

    // zero acts as one, too long acts as the cap
    always_comb begin
        if (pattern_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (pattern_len_reg > LEN_W'(CAP)) begin
            len_eff = LEN_W'(CAP);
        end else begin
            len_eff = pattern_len_reg;
        end
    end

    always_comb begin
        logic [LEN_W-1:0] idx;
        for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
            idx = len_eff - LEN_W'(p) - LEN_W'(1);
            if (p < int'(len_eff)) begin
                cell_cfg_next[p].in_use = 1'b1;
                cell_cfg_next[p].care   = care_mask_reg[idx[3:0]];
                cell_cfg_next[p].sig    = sig_bytes[idx[3:0]];
            end else begin
                cell_cfg_next[p] = '0;
            end
        end
    end

    // refreshed every cycle, so a write reaches the cells once it has passed this register
    always_ff @(posedge aclk) begin
        cell_cfg_reg <= cell_cfg_next;
        len_eff_reg  <= len_eff;
    end

    // ------------------------------------------------------------------
    // handshake and stage control
    // ------------------------------------------------------------------
    logic                   s_accept;
    logic                   stage_valid_reg;    // a byte sits in the window, untested
    logic                   stage_last_reg;
    logic                   stage_adv;          // the tested byte leaves this cycle
    logic [OFFSET_BITS-1:0] count_reg;          // bytes of this image, saturating
    logic                   match_reported_reg;
    logic                   m_tvalid_reg;
    logic                   m_found_reg;
    logic [OUT_OFFSET_W-1:0] m_offset_reg;

    logic                   window_hit;
    logic                   fire_match;
    logic                   fire_none;
    logic                   fire;
    logic [OFFSET_BITS-1:0] len_ext;
    logic [OFFSET_BITS-1:0] offset_diff;
    logic [EXT_W-1:0]       offset_ext;

    // stall only when a result must go out and the output register is held
    assign stage_adv = stage_valid_reg && (!fire || !m_tvalid_reg || m_tready);
    assign s_tready  = !stage_valid_reg || stage_adv;
    assign s_accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // window: chain of cells, newest byte enters cell 0
    // the oldest byte falls off the end of the chain
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]            win_byte [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_hit;

    for (genvar p = 0; p < MAX_PATTERN_BYTES; p++) begin : g_cell
        logic [BYTE_W-1:0] cell_in;
        if (p == 0) begin : g_head
            assign cell_in = s_tdata;
        end else begin : g_link
            assign cell_in = win_byte[p-1];
        end

        mbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_accept),
            .byte_in  (cell_in),
            .cfg      (cell_cfg_reg[p]),
            .byte_q   (win_byte[p]),
            .hit      (cell_hit[p])
        );
    end

    // ------------------------------------------------------------------
    // test of the byte in the window
    // stale bytes from an earlier image lie beyond the count and never decide a match
    // ------------------------------------------------------------------
    assign window_hit  = &cell_hit;
    assign len_ext     = OFFSET_BITS'(len_eff_reg);
    assign fire_match  = stage_valid_reg && !match_reported_reg &&
                         (count_reg >= len_ext) && window_hit;
    assign fire_none   = stage_valid_reg && stage_last_reg && !match_reported_reg &&
                         !fire_match;
    assign fire        = fire_match || fire_none;
    assign offset_diff = count_reg - len_ext;
    assign offset_ext  = EXT_W'(offset_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg    <= 1'b0;
            stage_last_reg     <= 1'b0;
            count_reg          <= '0;
            match_reported_reg <= 1'b0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            // byte count: restarts after an image's last byte
            if (s_accept) begin
                stage_valid_reg <= 1'b1;
                stage_last_reg  <= s_tlast;
                if (stage_valid_reg && stage_last_reg) begin
                    count_reg <= OFFSET_BITS'(1);
                end else if (count_reg != '1) begin
                    count_reg <= count_reg + OFFSET_BITS'(1);
                end
            end else if (stage_adv) begin
                stage_valid_reg <= 1'b0;
                if (stage_last_reg) begin
                    count_reg <= '0;
                end
            end

            // one result per image
            if (stage_adv) begin
                if (stage_last_reg) begin
                    match_reported_reg <= 1'b0;
                end else if (fire_match) begin
                    match_reported_reg <= 1'b1;
                end
            end

            // output register
            if (stage_adv && fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_adv && fire) begin
            m_found_reg  <= fire_match;
            m_offset_reg <= fire_match ? offset_ext[OUT_OFFSET_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = m_offset_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `MBPS_ASSERT_IMPLIES(a_stall_only_on_held_result, aclk, aresetn,
        !s_tready, m_tvalid_reg, "input stalled without a result held at the output")
    `MBPS_ASSERT_IMPLIES(a_count_covers_staged_byte, aclk, aresetn,
        stage_valid_reg, count_reg != '0, "staged byte without a byte count")
    `MBPS_ASSERT_NEXT(a_result_from_staged_byte, aclk, aresetn,
        !m_tvalid_reg && !stage_valid_reg, !m_tvalid_reg,
        "result appeared with no byte under test")

endmodule

>>> dv/tb_masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked byte pattern scanner unit testbench
// streams byte images through the scanner under a range of signatures, care
// masks and lengths, predicts each first-match or not-found result in the
// bench and checks every result transfer in order, with random idling
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner_unit;

    import mbps_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 8;       // pipeline depth plus margin
    localparam int CYCLE_LIMIT   = 300000;  // far above the slowest correct run

    // one image byte as it goes out on the s_ side
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last_byte;
    } image_byte_t;

    // one scan result as it comes back on the m_ side
    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
    } scan_result_t;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [BYTE_W-1:0]       s_tdata  = '0;     // [7:0] image_byte
    logic                    s_tlast  = 1'b0;   // end_of_image
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_OFFSET_W-1:0] m_tdata;           // [31:0] match_offset
    logic                    m_tuser;           // [0] found
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    masked_byte_pattern_scanner_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    image_byte_t  bytes_to_send[$];     // filled by the sequence, drained by the driver
    scan_result_t results_due[$];       // predicted results, oldest first
    int unsigned  sender_idle_pct = 0;
    int unsigned  receiver_stall_pct = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    logic         byte_taken = 1'b0;    // s_ transfer seen at the last rising edge

    // shadow of the scanner: configuration and per-image scan state
    logic [63:0]       sig_low_q   = '0;
    logic [63:0]       sig_high_q  = '0;
    logic [15:0]       care_bits_q = CARE_MASK_RST;
    logic [LEN_W-1:0]  sig_len_q   = PATTERN_LEN_RST;
    logic [BYTE_W-1:0] recent_bytes [MAX_PATTERN_BYTES_DEF];  // newest at index 0
    logic [OFFSET_BITS_DEF-1:0] image_byte_count = '0;
    logic              hit_reported = 1'b0;

    initial begin
        foreach (recent_bytes[i]) recent_bytes[i] = '0;
    end

    // length actually compared: zero acts as one, oversize clamps to the bytes held
    function automatic int unsigned applied_length(input logic [LEN_W-1:0] len_field);
        int unsigned cap;
        int unsigned len_wide;
        cap = (MAX_PATTERN_BYTES_DEF < SIG_BYTES_HELD) ? MAX_PATTERN_BYTES_DEF
                                                        : SIG_BYTES_HELD;
        len_wide = 32'(len_field);
        if (len_wide == 0) return 1;
        if (len_wide > cap) return cap;
        return len_wide;
    endfunction

    // advance the shadow by one image byte and queue any result it causes
    task automatic scan_image_byte(input logic [BYTE_W-1:0] value, input logic last_byte);
        int unsigned  len;
        int           i;
        logic         hit;
        logic [127:0] sig;
        scan_result_t res;
        len = applied_length(sig_len_q);
        sig = {sig_high_q, sig_low_q};
        for (i = MAX_PATTERN_BYTES_DEF - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
        recent_bytes[0] = value;
        // count saturates rather than wrapping
        if (image_byte_count != '1) image_byte_count++;
        if (!hit_reported && image_byte_count >= len) begin
            hit = 1'b1;
            // signature byte i lines up with the byte len-1-i places back
            for (i = 0; i < len; i++) begin
                if (care_bits_q[i] && sig[8*i +: 8] != recent_bytes[len-1-i]) hit = 1'b0;
            end
            if (hit) begin
                res.found  = 1'b1;
                res.offset = OUT_OFFSET_W'(image_byte_count - len);
                results_due.push_back(res);
                hit_reported = 1'b1;
            end
        end
        if (last_byte) begin
            // no match in this image: not-found on its last byte
            if (!hit_reported) begin
                res.found  = 1'b0;
                res.offset = '0;
                results_due.push_back(res);
            end
            foreach (recent_bytes[k]) recent_bytes[k] = '0;
            image_byte_count = '0;
            hit_reported     = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: new byte at the falling edge once the previous one has moved
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        image_byte_t nxt;
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (bytes_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.value;
                s_tlast  <= nxt.last_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: predict on each byte transfer, check each result transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        scan_result_t want;
        byte_taken = s_tvalid && s_tready;
        if (byte_taken) scan_image_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("result transfer with none due: found %0d offset %0d",
                       m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata !== want.offset) begin
                    $error("match_offset: expected %0d, actual %0d", want.offset, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** masked_byte_pattern_scanner_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence helpers
    // ------------------------------------------------------------------------

    // apb write: setup cycle, access cycle, then update the shadow copy
    task automatic reg_write(input logic [1:0] reg_code, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (reg_code)
            REG_PATTERN_LOW:  sig_low_q   = value;
            REG_PATTERN_HIGH: sig_high_q  = value;
            REG_CARE_MASK:    care_bits_q = value[15:0];
            REG_PATTERN_LEN:  sig_len_q   = value[LEN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off until every byte has gone and every predicted result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (!(bytes_to_send.size() == 0 && !s_tvalid && results_due.size() == 0));
        // a byte with no result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // build one image and queue it; returns the number of bytes queued
    task automatic queue_image(input int unsigned len, input logic [127:0] sig,
                               input logic [15:0] care, input bit close_image,
                               output int unsigned n_bytes);
        logic [BYTE_W-1:0] img [$];
        int unsigned       style;
        int unsigned       start;
        int unsigned       k;
        image_byte_t       item;
        style = $urandom_range(99);
        if (style < 60)
            n_bytes = len + (($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(12));
        else if ($urandom_range(9) == 0)
            n_bytes = $urandom_range(1, 64);
        else
            n_bytes = $urandom_range(1, 24);
        // background drawn partly from the signature bytes to provoke near misses
        for (k = 0; k < n_bytes; k++) begin
            if (style < 85 && $urandom_range(1))
                img.push_back(sig[8*$urandom_range(15) +: 8]);
            else
                img.push_back(BYTE_W'($urandom_range(255)));
        end
        // plant the signature, wildcard places keep their random byte
        if (style < 60) begin
            start = $urandom_range(n_bytes - len);
            for (k = 0; k < len; k++) begin
                if (care[k]) img[start+k] = sig[8*k +: 8];
            end
        end
        for (k = 0; k < n_bytes; k++) begin
            item.value     = img[k];
            item.last_byte = close_image && (k == n_bytes - 1);
            bytes_to_send.push_back(item);
        end
    endtask

    // one phase: idle the block, load all four registers, then stream images
    task automatic run_phase(input logic [63:0] sig_lo, input logic [63:0] sig_hi,
                             input logic [15:0] care, input logic [LEN_W-1:0] len_field,
                             input int unsigned send_idle, input int unsigned recv_stall,
                             input int unsigned n_target, input bit leave_open,
                             input bit pause_midway);
        int unsigned queued;
        int unsigned n_img;
        bit          paused;
        bit          last_image;
        wait_drained();
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        reg_write(REG_PATTERN_LOW, sig_lo);
        reg_write(REG_PATTERN_HIGH, sig_hi);
        // unused upper bits carry junk; the block keeps only the field
        reg_write(REG_CARE_MASK, {32'($urandom), 16'($urandom), care});
        reg_write(REG_PATTERN_LEN, {32'($urandom), 27'($urandom), len_field});
        queued = 0;
        paused = 1'b0;
        while (queued < n_target) begin
            if (pause_midway && !paused && queued >= n_target / 2) begin
                // sender holds until the result side has caught up completely
                wait_drained();
                paused = 1'b1;
            end
            last_image = (queued + 24 >= n_target);
            queue_image(applied_length(len_field), {sig_hi, sig_lo}, care,
                        !(leave_open && last_image), n_img);
            queued += n_img;
            if (last_image) break;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        image_byte_t item;
        int          k;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: sixteen zero bytes, all cared
        // a leading 0xff pushes the only match onto the end byte, at offset 1
        item.value = 8'hFF;
        item.last_byte = 1'b0;
        bytes_to_send.push_back(item);
        for (k = 0; k < 16; k++) begin
            item.value = 8'h00;
            item.last_byte = (k == 15);
            bytes_to_send.push_back(item);
        end
        // images shorter than the pattern end as not-found
        item = '{8'h00, 1'b0}; bytes_to_send.push_back(item);
        item = '{8'hFF, 1'b0}; bytes_to_send.push_back(item);
        item = '{8'h80, 1'b1}; bytes_to_send.push_back(item);
        item = '{8'h7F, 1'b1}; bytes_to_send.push_back(item);

        // full length, all bytes cared, random signature
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16,
                  0, 0, 100, 1'b0, 1'b0);
        // single byte pattern
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'h0001, 5'd1,
                  82, 0, 100, 1'b0, 1'b0);
        // zero length with every byte a wildcard: each image hits at offset 0
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd0,
                  0, 82, 100, 1'b0, 1'b0);
        // oversize length clamps to sixteen; last image runs on into the next phase
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd31,
                  22, 22, 100, 1'b1, 1'b0);
        // all-ones signature, short length
        run_phase('1, '1, 16'($urandom), 5'd5,
                  0, 0, 100, 1'b0, 1'b0);
        // random length, sender pauses halfway for a full drain
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                  LEN_W'($urandom_range(1, 16)), 22, 22, 100, 1'b0, 1'b1);
        // all-zero signature, half length
        run_phase('0, '0, 16'hFFFF, 5'd8,
                  82, 0, 100, 1'b0, 1'b0);
        // full length, sparse wildcards
        run_phase({$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom) | 16'($urandom), 5'd16, 0, 82, 100, 1'b0, 1'b0);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("** masked_byte_pattern_scanner_unit: PASSED **");
        end else begin
            $display("** masked_byte_pattern_scanner_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/mbps_pkg.sv
design/mbps_cell.sv
design/masked_byte_pattern_scanner_unit.sv
dv/tb_masked_byte_pattern_scanner_unit.sv
